@@ rtl/core/mscr_pkg.sv @@
// shared types and constants for the utf-8 mixed script risk check
`timescale 1ns / 1ps

package mscr_pkg;

	// code point and state widths
	localparam int CP_W     = 21;
	localparam int CONT_W   = 2;
	localparam int SCRIPT_W = 6;

	// script class bits
	localparam int SCR_LATIN    = 0;
	localparam int SCR_GREEK    = 1;
	localparam int SCR_CYRILLIC = 2;
	localparam int SCR_HEBREW   = 3;
	localparam int SCR_ARABIC   = 4;
	localparam int SCR_OTHER    = 5;

	// configuration register indexes
	localparam logic [1:0] CFG_ALLOW_BIDI     = 2'd0;
	localparam logic [1:0] CFG_ALLOW_MIRRORED = 2'd1;
	localparam logic [1:0] CFG_ALLOW_MIXED    = 2'd2;
	localparam logic [1:0] CFG_ALLOW_TRANSLIT = 2'd3;

	// one input request
	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} in_item_t;

	// one verdict
	typedef struct packed {
		logic risky;
		logic malformed;
	} out_item_t;

	// policy register set
	typedef struct packed {
		logic allow_bidi;
		logic allow_mirrored;
		logic allow_mixed_scripts;
		logic allow_transliteration;
	} policy_t;

	// classification of one code point
	typedef struct packed {
		logic                is_bidi;
		logic                is_mirrored;
		logic [SCRIPT_W-1:0] script;
	} cp_class_t;

endpackage

@@ rtl/core/utf8_mixed_script_risk_check.sv @@
// top level: input register, decode stage, verdict register and policy registers
// path: a byte is taken into the input register, decoded combinationally there, and
//   the verdict for a last byte is registered into the output register behind out_data
// throughput: one byte per cycle; the decode stage only waits when a last byte
//   meets a verdict still held in the output register
// reset: arst_n clears the policy registers, decode state and all valid flags
`timescale 1ns / 1ps

module utf8_mixed_script_risk_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mscr_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mscr_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic                 cfg_data
);

	logic                valid_s1;
	mscr_pkg::in_item_t  item_s1;
	logic                step;
	logic                out_valid_q;
	mscr_pkg::out_item_t out_data_q;
	mscr_pkg::out_item_t verdict;
	mscr_pkg::policy_t   policy_q;

	// stage advance: a last byte needs room in the output register
	assign step      = valid_s1 && (!item_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || step;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	mscr_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.policy  (policy_q),
		.verdict (verdict)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_byte) begin
			out_data_q <= verdict;
		end
	end

	// policy registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mscr_pkg::CFG_ALLOW_BIDI:     policy_q.allow_bidi            <= cfg_data;
				mscr_pkg::CFG_ALLOW_MIRRORED: policy_q.allow_mirrored        <= cfg_data;
				mscr_pkg::CFG_ALLOW_MIXED:    policy_q.allow_mixed_scripts   <= cfg_data;
				mscr_pkg::CFG_ALLOW_TRANSLIT: policy_q.allow_transliteration <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/mscr_class.sv @@
// range compares that sort one code point into a script class
`timescale 1ns / 1ps

module mscr_class (
	input  logic [mscr_pkg::CP_W-1:0] cp,
	output mscr_pkg::cp_class_t       cls
);

	// bidi controls and mirrored punctuation
	always_comb begin
		cls = '0;
		cls.is_bidi = (cp >= 21'h0202A && cp <= 21'h0202E) ||
			(cp >= 21'h02066 && cp <= 21'h02069);
		cls.is_mirrored = (cp == 21'h0061B) || (cp == 21'h0061F) ||
			(cp == 21'h0FD3E) || (cp == 21'h0FD3F);

		// first matching range wins
		priority if ((cp >= 21'h000C0 && cp <= 21'h0024F) ||
			(cp >= 21'h01E00 && cp <= 21'h01EFF)) begin
			cls.script[mscr_pkg::SCR_LATIN] = 1'b1;
		end else if ((cp >= 21'h00370 && cp <= 21'h003FF) ||
			(cp >= 21'h01F00 && cp <= 21'h01FFF)) begin
			cls.script[mscr_pkg::SCR_GREEK] = 1'b1;
		end else if (cp >= 21'h00400 && cp <= 21'h0052F) begin
			cls.script[mscr_pkg::SCR_CYRILLIC] = 1'b1;
		end else if (cp >= 21'h00590 && cp <= 21'h005FF) begin
			cls.script[mscr_pkg::SCR_HEBREW] = 1'b1;
		end else if (cp >= 21'h00600 && cp <= 21'h006FF) begin
			cls.script[mscr_pkg::SCR_ARABIC] = 1'b1;
		end else begin
			cls.script[mscr_pkg::SCR_OTHER] = 1'b1;
		end
	end

endmodule

@@ rtl/core/mscr_decode.sv @@
// utf-8 decode state, per-identifier flags and verdict logic
`timescale 1ns / 1ps

module mscr_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  mscr_pkg::in_item_t    item,
	input  mscr_pkg::policy_t     policy,
	output mscr_pkg::out_item_t   verdict
);

	logic [mscr_pkg::CONT_W-1:0]   cont_q, cont_n;
	logic [mscr_pkg::CP_W-1:0]     acc_q, acc_n, acc_shift, cp;
	logic                          mal_q, mal_n;
	logic                          forb_q, forb_n;
	logic [mscr_pkg::SCRIPT_W-1:0] scripts_q, scripts_n;
	logic                          cp_done;
	logic                          multi_script;
	logic                          bad;
	mscr_pkg::cp_class_t           cls;

	mscr_class u_class (
		.cp  (cp),
		.cls (cls)
	);

	assign acc_shift = {acc_q[mscr_pkg::CP_W-7:0], item.text_byte[5:0]};

	// byte decode and state update
	always_comb begin
		cont_n    = cont_q;
		acc_n     = acc_q;
		mal_n     = mal_q;
		forb_n    = forb_q;
		scripts_n = scripts_q;
		cp_done   = 1'b0;
		cp        = acc_shift;
		if (cont_q == '0) begin
			cp = {13'd0, item.text_byte};
			priority if (item.text_byte[7] == 1'b0) begin
				cp_done = 1'b1;
			end else if (item.text_byte[7:5] == 3'b110) begin
				acc_n  = {16'd0, item.text_byte[4:0]};
				cont_n = 2'd1;
			end else if (item.text_byte[7:4] == 4'b1110) begin
				acc_n  = {17'd0, item.text_byte[3:0]};
				cont_n = 2'd2;
			end else if (item.text_byte[7:3] == 5'b11110) begin
				acc_n  = {18'd0, item.text_byte[2:0]};
				cont_n = 2'd3;
			end else begin
				mal_n = 1'b1;
			end
		end else if (item.text_byte[7:6] != 2'b10) begin
			mal_n  = 1'b1;
			cont_n = '0;
			acc_n  = '0;
		end else begin
			acc_n  = acc_shift;
			cont_n = cont_q - 2'd1;
			cp_done = (cont_q == 2'd1);
		end

		// take a finished non-ascii code point
		if (cp_done && cp >= 21'h00080) begin
			priority if (cls.is_bidi && !policy.allow_bidi) begin
				forb_n = 1'b1;
			end else if (cls.is_mirrored && !policy.allow_mirrored) begin
				forb_n = 1'b1;
			end else begin
				scripts_n = scripts_q | cls.script;
			end
		end
	end

	// verdict from the state after this byte
	assign multi_script = (scripts_n & (scripts_n - 6'd1)) != '0;
	assign bad          = mal_n || (cont_n != '0);
	always_comb begin
		verdict.malformed = bad;
		verdict.risky = bad || forb_n ||
			(multi_script && !policy.allow_mixed_scripts) ||
			((scripts_n[mscr_pkg::SCR_GREEK] || scripts_n[mscr_pkg::SCR_CYRILLIC]) &&
			 !policy.allow_transliteration);
	end

	// state registers, cleared after each identifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q    <= '0;
			acc_q     <= '0;
			mal_q     <= 1'b0;
			forb_q    <= 1'b0;
			scripts_q <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				cont_q    <= '0;
				acc_q     <= '0;
				mal_q     <= 1'b0;
				forb_q    <= 1'b0;
				scripts_q <= '0;
			end else begin
				cont_q    <= cont_n;
				acc_q     <= acc_n;
				mal_q     <= mal_n;
				forb_q    <= forb_n;
				scripts_q <= scripts_n;
			end
		end
	end

endmodule
